### hdl/qau_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Operation codes, status codes, queue sizing and control structures shared
// by the front end, the back end and the normalize unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_DOT  = 3'd1,
        OP_NEG  = 3'd2,
        OP_NORM = 3'd3,
        OP_MAT  = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Classification made by the front end for each queued beat.
    typedef struct packed {
        op_t  op;
        logic self_prod;   // products are a times a instead of a times b
    } qau_tag_t;

    typedef enum logic [2:0] {
        NORM_IDLE,
        NORM_SQRT,
        NORM_DIV,
        NORM_ROUND,
        NORM_DONE
    } norm_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } qau_norm_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } qau_norm_sts_t;

endpackage

### hdl/qau_front.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit front end
// Accepts input beats, drops unknown operations and queues the rest.
// ----------------------------------------------------------------------------
module qau_front
    import qau_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  op,
    input  logic signed [WORD_BITS-1:0] a [4],
    input  logic signed [WORD_BITS-1:0] b [4],
    output logic                        q_valid,
    input  logic                        q_ready,
    output qau_tag_t                    q_tag,
    output logic signed [WORD_BITS-1:0] q_a [4],
    output logic signed [WORD_BITS-1:0] q_b [4]
);

    qau_tag_t                    tag_mem [QDEPTH];
    logic signed [WORD_BITS-1:0] a_mem   [QDEPTH][4];
    logic signed [WORD_BITS-1:0] b_mem   [QDEPTH][4];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push, pop, known;
    qau_tag_t          tag_in;

    assign in_stall = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign known    = (op <= OP_MAT);
    assign push     = in_valid && !in_stall && known;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        tag_in.op        = op_t'(op);
        tag_in.self_prod = (op_t'(op) == OP_MAT) || (op_t'(op) == OP_NORM);
        wr_ptr_next      = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next      = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next       = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tag_mem[wr_ptr_reg] <= tag_in;
            a_mem[wr_ptr_reg]   <= a;
            b_mem[wr_ptr_reg]   <= b;
        end
    end

    assign q_tag = tag_mem[rd_ptr_reg];
    assign q_a   = a_mem[rd_ptr_reg];
    assign q_b   = b_mem[rd_ptr_reg];

endmodule

### hdl/qau_norm.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit normalize engine
// Bit-serial square root of the sum of squares, then four bit-serial
// dividers that scale each magnitude by one over the root, rounded.
// ----------------------------------------------------------------------------
module qau_norm
    import qau_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  qau_norm_ctl_t                      ctl,
    output qau_norm_sts_t                      sts,
    input  logic [2*WORD_BITS:0]               rad,
    input  logic [WORD_BITS-1:0]               mag [4],
    output logic [WORD_BITS+FRAC_BITS:0]       quot [4]
);

    localparam int W   = WORD_BITS;
    localparam int NW  = WORD_BITS + FRAC_BITS;
    localparam int SQP = 2*WORD_BITS + 2;
    localparam int CW  = $clog2(NW + 1);

    norm_state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [SQP-1:0] rad_reg;
    logic [W+1:0]   srem_reg;
    logic [W:0]     root_reg;
    logic [NW-1:0]  num_reg  [4];
    logic [W:0]     drem_reg [4];
    logic [NW-1:0]  q_reg    [4];
    logic [NW:0]    quot_reg [4];

    logic [W+3:0]   cur, trial, sq_diff;
    logic [W+1:0]   sh      [4];
    logic [W+1:0]   dv_diff [4];
    logic [W+1:0]   msor;

    assign sts.idle = (state_reg == NORM_IDLE);
    assign sts.done = (state_reg == NORM_DONE);
    assign quot     = quot_reg;

    always_comb
    begin
        cur     = {srem_reg, rad_reg[SQP-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        sq_diff = cur - trial;
        msor    = {1'b0, root_reg};
        for (int i = 0; i < 4; i++)
        begin
            sh[i]      = {drem_reg[i], num_reg[i][NW-1]};
            dv_diff[i] = sh[i] - msor;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            NORM_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = NORM_SQRT;
                    cnt_next   = CW'(W + 1);
                end
            end
            NORM_SQRT:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = NORM_DIV;
                    cnt_next   = CW'(NW);
                end
            end
            NORM_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = NORM_ROUND;
                end
            end
            NORM_ROUND:
            begin
                state_next = NORM_DONE;
            end
            NORM_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = NORM_IDLE;
                end
            end
            default:
            begin
                state_next = NORM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= NORM_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            NORM_IDLE:
            begin
                rad_reg  <= {1'b0, rad};
                srem_reg <= '0;
                root_reg <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    num_reg[i] <= {mag[i], {FRAC_BITS{1'b0}}};
                end
            end
            NORM_SQRT:
            begin
                rad_reg <= {rad_reg[SQP-3:0], 2'b00};
                if (cur >= trial)
                begin
                    srem_reg <= sq_diff[W+1:0];
                    root_reg <= {root_reg[W-1:0], 1'b1};
                end
                else
                begin
                    srem_reg <= cur[W+1:0];
                    root_reg <= {root_reg[W-1:0], 1'b0};
                end
                for (int i = 0; i < 4; i++)
                begin
                    drem_reg[i] <= '0;
                    q_reg[i]    <= '0;
                end
            end
            NORM_DIV:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    num_reg[i] <= {num_reg[i][NW-2:0], 1'b0};
                    if (sh[i] >= msor)
                    begin
                        drem_reg[i] <= dv_diff[i][W:0];
                        q_reg[i]    <= {q_reg[i][NW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[i] <= sh[i][W:0];
                        q_reg[i]    <= {q_reg[i][NW-2:0], 1'b0};
                    end
                end
            end
            NORM_ROUND:
            begin
                // Half a unit or more left over rounds the quotient up.
                for (int i = 0; i < 4; i++)
                begin
                    quot_reg[i] <= {1'b0, q_reg[i]}
                                 + (NW+1)'({drem_reg[i], 1'b0} >= msor);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### hdl/qau_back.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit back end
// Multiplies all component pairs, combines them per operation (one matrix
// column per unstalled cycle), rounds and saturates into the output register.
// ----------------------------------------------------------------------------
module qau_back
    import qau_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  qau_tag_t                    q_tag,
    input  logic signed [WORD_BITS-1:0] q_a [4],
    input  logic signed [WORD_BITS-1:0] q_b [4],
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] res [4],
    output logic                        last,
    output logic [1:0]                  status
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2*WORD_BITS;
    localparam int NW  = WORD_BITS + FRAC_BITS;
    localparam int SQW = 2*WORD_BITS + 1;
    localparam int S1  = 2*WORD_BITS + 3;
    localparam int S2  = WORD_BITS + FRAC_BITS + 2;
    localparam int S3  = 2*FRAC_BITS + 2;
    localparam int S12 = (S1 > S2) ? S1 : S2;
    localparam int SW  = (S12 > S3) ? S12 : S3;

    localparam logic signed [SW-1:0] ONE2 = SW'(1) << (2*F);
    localparam logic signed [SW-1:0] HALF = SW'(1) << (F-1);

    // Multiply stage
    logic                 m_valid_reg;
    op_t                  m_op_reg;
    logic signed [W-1:0]  m_a_reg    [4];
    logic signed [PW-1:0] m_prod_reg [16];
    logic [1:0]           m_col_reg, m_col_next;
    logic                 m_release;

    // Combine stage
    logic                 c_valid_reg;
    logic signed [SW-1:0] c_s_reg [4];
    logic                 c_shift_reg, c_last_reg, c_zero_reg;
    logic signed [SW-1:0] c_s_next [4];
    logic                 c_shift_next, c_last_next, c_zero_next;
    logic                 c_load, c_ready;

    // Output register
    logic                 out_valid_reg;
    logic signed [W-1:0]  out_res_reg [4];
    logic                 out_last_reg;
    logic [1:0]           out_status_reg;
    logic                 out_adv;

    logic signed [SW-1:0] pe [16];
    logic [SQW-1:0]       sum_sq, rad;
    logic                 sum_zero;
    logic [W-1:0]         mag [4];
    logic [NW:0]          quot [4];
    qau_norm_ctl_t        nctl;
    qau_norm_sts_t        nsts;

    logic signed [SW-1:0] rnd [4];
    logic signed [W-1:0]  sat_v [4];
    logic [3:0]           sat_hit;

    assign out_adv   = !out_valid_reg || !out_stall;
    assign c_ready   = !c_valid_reg || out_adv;
    assign q_ready   = !m_valid_reg || m_release;
    assign out_valid = out_valid_reg;
    assign res       = out_res_reg;
    assign last      = out_last_reg;
    assign status    = out_status_reg;

    // Multiply stage: sixteen products of a with b, or of a with itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_col_reg   <= '0;
        end
        else
        begin
            m_col_reg <= m_col_next;
            if (q_ready)
            begin
                m_valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ready && q_valid)
        begin
            m_op_reg <= q_tag.op;
            m_a_reg  <= q_a;
            for (int l = 0; l < 4; l++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    m_prod_reg[l*4+r] <= q_a[l] * (q_tag.self_prod ? q_a[r] : q_b[r]);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            pe[i] = SW'(m_prod_reg[i]);
        end
        sum_sq = SQW'(unsigned'(m_prod_reg[0]))  + SQW'(unsigned'(m_prod_reg[5]))
               + SQW'(unsigned'(m_prod_reg[10])) + SQW'(unsigned'(m_prod_reg[15]));
        sum_zero = (sum_sq == '0);
        rad = sum_sq;
        // When SQW exceeds 128, a sum with its top bit set clamps to the largest (SQW-1)-bit value.
        if (SQW > 128 && sum_sq[SQW-1])
        begin
            rad = {1'b0, {(SQW-1){1'b1}}};
        end
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = m_a_reg[i][W-1] ? W'(-m_a_reg[i]) : W'(m_a_reg[i]);
        end
    end

    qau_norm #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (nctl),
        .sts   (nsts),
        .rad   (rad),
        .mag   (mag),
        .quot  (quot)
    );

    // Combine stage: one result beat worth of exact sums, negated values or normalize quotients.
    always_comb
    begin
        c_load       = 1'b0;
        m_release    = 1'b0;
        m_col_next   = m_col_reg;
        nctl.start   = 1'b0;
        nctl.ack     = 1'b0;
        c_shift_next = 1'b1;
        c_last_next  = 1'b1;
        c_zero_next  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            c_s_next[i] = '0;
        end

        if (m_valid_reg)
        begin
            case (m_op_reg)
                OP_MUL:
                begin
                    c_s_next[0] = pe[12] + pe[3] + pe[6] - pe[9];
                    c_s_next[1] = pe[13] + pe[7] + pe[8] - pe[2];
                    c_s_next[2] = pe[14] + pe[11] + pe[1] - pe[4];
                    c_s_next[3] = pe[15] - pe[0] - pe[5] - pe[10];
                    c_load      = c_ready;
                    m_release   = c_ready;
                end
                OP_DOT:
                begin
                    c_s_next[0] = pe[0] + pe[5] + pe[10] + pe[15];
                    c_load      = c_ready;
                    m_release   = c_ready;
                end
                OP_NEG:
                begin
                    c_shift_next = 1'b0;
                    c_s_next[0]  = SW'(m_a_reg[0]);
                    c_s_next[1]  = SW'(m_a_reg[1]);
                    c_s_next[2]  = SW'(m_a_reg[2]);
                    c_s_next[3]  = -SW'(m_a_reg[3]);
                    c_load       = c_ready;
                    m_release    = c_ready;
                end
                OP_MAT:
                begin
                    case (m_col_reg)
                        2'd0:
                        begin
                            c_s_next[0] = ONE2 - ((pe[5] + pe[10]) <<< 1);
                            c_s_next[1] = (pe[1] + pe[14]) <<< 1;
                            c_s_next[2] = (pe[2] - pe[13]) <<< 1;
                        end
                        2'd1:
                        begin
                            c_s_next[0] = (pe[1] - pe[14]) <<< 1;
                            c_s_next[1] = ONE2 - ((pe[0] + pe[10]) <<< 1);
                            c_s_next[2] = (pe[6] + pe[12]) <<< 1;
                        end
                        2'd2:
                        begin
                            c_s_next[0] = (pe[2] + pe[13]) <<< 1;
                            c_s_next[1] = (pe[6] - pe[12]) <<< 1;
                            c_s_next[2] = ONE2 - ((pe[0] + pe[5]) <<< 1);
                        end
                        default:
                        begin
                            c_s_next[3] = ONE2;
                        end
                    endcase
                    c_last_next = (m_col_reg == 2'd3);
                    c_load      = c_ready;
                    if (c_ready)
                    begin
                        m_col_next = m_col_reg + 1'b1;
                        m_release  = (m_col_reg == 2'd3);
                    end
                end
                OP_NORM:
                begin
                    c_shift_next = 1'b0;
                    if (sum_zero)
                    begin
                        c_zero_next = 1'b1;
                        c_load      = c_ready;
                        m_release   = c_ready;
                    end
                    else
                    begin
                        nctl.start = nsts.idle;
                        for (int i = 0; i < 4; i++)
                        begin
                            c_s_next[i] = m_a_reg[i][W-1] ? -SW'(quot[i]) : SW'(quot[i]);
                        end
                        if (nsts.done && c_ready)
                        begin
                            nctl.ack  = 1'b1;
                            c_load    = 1'b1;
                            m_release = 1'b1;
                        end
                    end
                end
                default:
                begin
                    m_release = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_load)
        begin
            c_valid_reg <= 1'b1;
        end
        else if (out_adv)
        begin
            c_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_s_reg     <= c_s_next;
            c_shift_reg <= c_shift_next;
            c_last_reg  <= c_last_next;
            c_zero_reg  <= c_zero_next;
        end
    end

    // Round to nearest (ties up) and clamp to the word range.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rnd[i] = c_shift_reg ? ((c_s_reg[i] + HALF) >>> F) : c_s_reg[i];
            if ((rnd[i][SW-1:W-1] == '0) || (rnd[i][SW-1:W-1] == '1))
            begin
                sat_hit[i] = 1'b0;
                sat_v[i]   = rnd[i][W-1:0];
            end
            else
            begin
                sat_hit[i] = 1'b1;
                sat_v[i]   = rnd[i][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && c_valid_reg)
        begin
            out_res_reg  <= sat_v;
            out_last_reg <= c_last_reg;
            if (c_zero_reg)
            begin
                out_status_reg <= ST_ZERO;
            end
            else if (sat_hit != '0)
            begin
                out_status_reg <= ST_SAT;
            end
            else
            begin
                out_status_reg <= ST_OK;
            end
        end
    end

endmodule

### hdl/quaternion_arithmetic_unit.sv
// Path: an accepted input beat passes through the queue, the multiply stage,
// the combine stage and the output register; normalize also runs the square
// root, divide and round states. Throughput: multiply, dot and negate-w take
// one beat per cycle while out_stall is low; to-matrix gives four result beats
// (one column each); normalize takes no new beat until its dividers finish.
// Reset: rst_n clears the queue and every pipeline valid at once.
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Signed fixed-point quaternion multiply, dot product, negate-w, normalize
// and rotation-matrix expansion behind a decoupling queue.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  op,
    input  logic signed [WORD_BITS-1:0] a_x,
    input  logic signed [WORD_BITS-1:0] a_y,
    input  logic signed [WORD_BITS-1:0] a_z,
    input  logic signed [WORD_BITS-1:0] a_w,
    input  logic signed [WORD_BITS-1:0] b_x,
    input  logic signed [WORD_BITS-1:0] b_y,
    input  logic signed [WORD_BITS-1:0] b_z,
    input  logic signed [WORD_BITS-1:0] b_w,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] res_0,
    output logic signed [WORD_BITS-1:0] res_1,
    output logic signed [WORD_BITS-1:0] res_2,
    output logic signed [WORD_BITS-1:0] res_3,
    output logic                        last,
    output logic [1:0]                  status
);

    // The front end classifies each beat and drops unknown operation codes;
    // the queue between the two halves lets the back end run a long
    // normalize or a four-column matrix while new beats keep arriving.
    logic signed [WORD_BITS-1:0] a_vec [4];
    logic signed [WORD_BITS-1:0] b_vec [4];
    logic signed [WORD_BITS-1:0] q_a   [4];
    logic signed [WORD_BITS-1:0] q_b   [4];
    logic signed [WORD_BITS-1:0] res_vec [4];
    logic                        q_valid, q_ready;
    qau_tag_t                    q_tag;

    assign a_vec[0] = a_x;
    assign a_vec[1] = a_y;
    assign a_vec[2] = a_z;
    assign a_vec[3] = a_w;
    assign b_vec[0] = b_x;
    assign b_vec[1] = b_y;
    assign b_vec[2] = b_z;
    assign b_vec[3] = b_w;

    qau_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .a        (a_vec),
        .b        (b_vec),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_tag    (q_tag),
        .q_a      (q_a),
        .q_b      (q_b)
    );

    // The combine stage and the output register each hold one beat, so a
    // stalled result beat holds up the multiply stage only once both are full.
    qau_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_tag     (q_tag),
        .q_a       (q_a),
        .q_b       (q_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res_vec),
        .last      (last),
        .status    (status)
    );

    assign res_0 = res_vec[0];
    assign res_1 = res_vec[1];
    assign res_2 = res_vec[2];
    assign res_3 = res_vec[3];

endmodule
